@@ hw/rtl/bmw_pkg.sv @@
`timescale 1ns / 1ps
package bmw_pkg;

  localparam int CFG_W       = 49;
  localparam int MASK_W      = 49;
  localparam int MASK_STRIDE = 7;
  localparam int ELEM_W      = 3;
  localparam int IMG_W       = 11;
  localparam int REG_W       = 3;

  localparam logic [REG_W-1:0] REG_MODE      = 3'd0;
  localparam logic [REG_W-1:0] REG_MASK      = 3'd1;
  localparam logic [REG_W-1:0] REG_ELEM_ROWS = 3'd2;
  localparam logic [REG_W-1:0] REG_ELEM_COLS = 3'd3;
  localparam logic [REG_W-1:0] REG_ORG_ROW   = 3'd4;
  localparam logic [REG_W-1:0] REG_ORG_COL   = 3'd5;
  localparam logic [REG_W-1:0] REG_IMG_ROWS  = 3'd6;
  localparam logic [REG_W-1:0] REG_IMG_COLS  = 3'd7;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QLW    = $clog2(QDEPTH + 1);

  // element settings after clamping
  typedef struct packed {
    logic              mode;
    logic [MASK_W-1:0] mask;
    logic [ELEM_W-1:0] rows;
    logic [ELEM_W-1:0] cols;
    logic [ELEM_W-1:0] orow;
    logic [ELEM_W-1:0] ocol;
  } elem_cfg_t;

endpackage

@@ hw/rtl/bmw_if.sv @@
`timescale 1ns / 1ps
interface bmw_in_if;
  logic valid;
  logic ready;
  logic pixel_in;
  logic drain;
  modport source (output valid, pixel_in, drain, input ready);
  modport sink (input valid, pixel_in, drain, output ready);
endinterface

interface bmw_out_if;
  logic valid;
  logic ready;
  logic pixel_out;
  logic frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

@@ hw/rtl/bmw_front.sv @@
`timescale 1ns / 1ps
module bmw_front import bmw_pkg::*; #(
  parameter int M        = 7,
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [REG_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]      cfg_data,
  bmw_in_if.sink                in_ch,
  input  logic                  room,
  input  logic                  clr_busy,
  output elem_cfg_t             ecfg,
  output logic [$clog2(MAX_ROWS+1)-1:0] nrows,
  output logic [$clog2(MAX_COLS+1)-1:0] ncols,
  output logic                  we,
  output logic [$clog2(2*M)-1:0] w_ring,
  output logic [$clog2(MAX_COLS+1)-1:0] w_col,
  output logic                  w_pix,
  output logic                  re,
  output logic [$clog2(MAX_ROWS+1)-1:0] j_row,
  output logic [$clog2(MAX_COLS+1)-1:0] j_col,
  output logic [$clog2(2*M)-1:0] j_ring,
  output logic                  j_last
);

  localparam int RING = 2 * M;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int GW   = $clog2(RING);
  localparam int PW   = $clog2(MAX_ROWS * MAX_COLS) + 2;
  localparam int DCW  = $clog2(PW + 1);

  logic              mode;
  logic [MASK_W-1:0] element_mask;
  logic [ELEM_W-1:0] element_rows, element_cols, origin_row, origin_col;
  logic [IMG_W-1:0]  image_rows, image_cols;

  logic [ELEM_W-1:0] er, ec, oi, oj;
  logic [PW-1:0]     total, lag;

  logic [PW-1:0] ip, op, ip_next, op_next;
  logic [RW-1:0] irow, orow, irow_next, orow_next;
  logic [CW-1:0] icol, ocol, icol_next, ocol_next;
  logic [GW-1:0] iring, oring, iring_next, oring_next;

  logic [PW-1:0] ip0, op0, ip1, op1;
  logic [RW-1:0] irow0, orow0, irow1, orow1;
  logic [CW-1:0] icol0, ocol0, icol1, ocol1;
  logic [GW-1:0] iring0, oring0, iring1, oring1;
  logic          restart, wr, emit, accept;

  // position recompute after any configuration write
  logic [DCW-1:0] div_cnt;
  logic [PW-1:0]  dd_i, dd_o;
  logic [CW-1:0]  rem_i, rem_o, ri_n, ro_n;
  logic [RW-1:0]  quot_i, quot_o, qi_n, qo_n;
  logic [GW-1:0]  m_i, m_o, mi_n, mo_n;
  logic [CW:0]    ti, to;
  logic [GW:0]    mi2, mo2;
  logic           qbi, qbo;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      element_mask <= '0;
      element_rows <= 3'd3;
      element_cols <= 3'd3;
      origin_row   <= 3'd1;
      origin_col   <= 3'd1;
      image_rows   <= 11'd1024;
      image_cols   <= 11'd1024;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:      mode         <= cfg_data[0];
        REG_MASK:      element_mask <= cfg_data[MASK_W-1:0];
        REG_ELEM_ROWS: element_rows <= cfg_data[ELEM_W-1:0];
        REG_ELEM_COLS: element_cols <= cfg_data[ELEM_W-1:0];
        REG_ORG_ROW:   origin_row   <= cfg_data[ELEM_W-1:0];
        REG_ORG_COL:   origin_col   <= cfg_data[ELEM_W-1:0];
        REG_IMG_ROWS:  image_rows   <= cfg_data[IMG_W-1:0];
        REG_IMG_COLS:  image_cols   <= cfg_data[IMG_W-1:0];
      endcase
    end
  end

  always_comb begin
    if (image_rows == '0)                 nrows = RW'(1);
    else if (int'(image_rows) > MAX_ROWS) nrows = RW'(MAX_ROWS);
    else                                  nrows = RW'(image_rows);
    if (image_cols == '0)                 ncols = CW'(1);
    else if (int'(image_cols) > MAX_COLS) ncols = CW'(MAX_COLS);
    else                                  ncols = CW'(image_cols);
    if (element_rows == '0)               er = ELEM_W'(1);
    else if (int'(element_rows) > M)      er = ELEM_W'(M);
    else                                  er = element_rows;
    if (element_cols == '0)               ec = ELEM_W'(1);
    else if (int'(element_cols) > M)      ec = ELEM_W'(M);
    else                                  ec = element_cols;
    oi = (origin_row > er - 1'b1) ? er - 1'b1 : origin_row;
    oj = (origin_col > ec - 1'b1) ? ec - 1'b1 : origin_col;
    total = PW'(nrows) * PW'(ncols);
    lag   = PW'(er - 1'b1) * PW'(ncols) + PW'(ec - 1'b1);
  end

  assign ecfg = '{mode: mode, mask: element_mask, rows: er, cols: ec, orow: oi, ocol: oj};

  assign in_ch.ready = !clr_busy && !cfg_we && (div_cnt == '0) && room;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    restart = (op >= total) || (ip < op);
    ip0     = restart ? '0 : ip;
    op0     = restart ? '0 : op;
    irow0   = restart ? '0 : irow;
    icol0   = restart ? '0 : icol;
    iring0  = restart ? '0 : iring;
    orow0   = restart ? '0 : orow;
    ocol0   = restart ? '0 : ocol;
    oring0  = restart ? '0 : oring;

    wr    = !in_ch.drain && (ip0 < total);
    ip1   = (wr || ip0 >= total) ? ip0 + 1'b1 : ip0;
    irow1 = irow0;
    icol1 = icol0;
    iring1 = iring0;
    if (wr) begin
      if (icol0 == ncols - 1'b1) begin
        icol1  = '0;
        irow1  = irow0 + 1'b1;
        iring1 = (iring0 == GW'(RING - 1)) ? '0 : iring0 + 1'b1;
      end else begin
        icol1 = icol0 + 1'b1;
      end
    end

    emit  = (ip1 - op0) > lag;
    op1   = op0;
    orow1 = orow0;
    ocol1 = ocol0;
    oring1 = oring0;
    if (emit) begin
      op1 = op0 + 1'b1;
      if (ocol0 == ncols - 1'b1) begin
        ocol1  = '0;
        orow1  = orow0 + 1'b1;
        oring1 = (oring0 == GW'(RING - 1)) ? '0 : oring0 + 1'b1;
      end else begin
        ocol1 = ocol0 + 1'b1;
      end
      if (op1 >= total) begin
        ip1    = '0;
        op1    = '0;
        irow1  = '0;
        icol1  = '0;
        iring1 = '0;
        orow1  = '0;
        ocol1  = '0;
        oring1 = '0;
      end
    end
  end

  assign we     = accept && wr;
  assign w_ring = iring0;
  assign w_col  = icol0;
  assign w_pix  = in_ch.pixel_in;
  assign re     = accept && emit;
  assign j_row  = orow0;
  assign j_col  = ocol0;
  assign j_ring = oring0;
  assign j_last = (op0 == total - 1'b1);

  // one quotient bit a cycle; row modulo ring depth built alongside
  always_comb begin
    ti   = {rem_i, dd_i[PW-1]};
    qbi  = ti >= {1'b0, ncols};
    ri_n = qbi ? CW'(ti - {1'b0, ncols}) : CW'(ti);
    qi_n = {quot_i[RW-2:0], qbi};
    mi2  = {m_i, qbi};
    mi_n = (int'(mi2) >= RING) ? GW'(int'(mi2) - RING) : GW'(mi2);
    to   = {rem_o, dd_o[PW-1]};
    qbo  = to >= {1'b0, ncols};
    ro_n = qbo ? CW'(to - {1'b0, ncols}) : CW'(to);
    qo_n = {quot_o[RW-2:0], qbo};
    mo2  = {m_o, qbo};
    mo_n = (int'(mo2) >= RING) ? GW'(int'(mo2) - RING) : GW'(mo2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cfg_we) begin
      div_cnt <= DCW'(PW);
    end else if (div_cnt != '0) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg_we) begin
      dd_i   <= ip;
      dd_o   <= op;
      rem_i  <= '0;
      rem_o  <= '0;
      quot_i <= '0;
      quot_o <= '0;
      m_i    <= '0;
      m_o    <= '0;
    end else if (div_cnt != '0) begin
      dd_i   <= dd_i << 1;
      dd_o   <= dd_o << 1;
      rem_i  <= ri_n;
      rem_o  <= ro_n;
      quot_i <= qi_n;
      quot_o <= qo_n;
      m_i    <= mi_n;
      m_o    <= mo_n;
    end
  end

  always_comb begin
    ip_next    = ip;
    op_next    = op;
    irow_next  = irow;
    icol_next  = icol;
    iring_next = iring;
    orow_next  = orow;
    ocol_next  = ocol;
    oring_next = oring;
    if (div_cnt == DCW'(1)) begin
      irow_next  = qi_n;
      icol_next  = ri_n;
      iring_next = mi_n;
      orow_next  = qo_n;
      ocol_next  = ro_n;
      oring_next = mo_n;
    end else if (accept) begin
      ip_next    = ip1;
      op_next    = op1;
      irow_next  = irow1;
      icol_next  = icol1;
      iring_next = iring1;
      orow_next  = orow1;
      ocol_next  = ocol1;
      oring_next = oring1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip    <= '0;
      op    <= '0;
      irow  <= '0;
      icol  <= '0;
      iring <= '0;
      orow  <= '0;
      ocol  <= '0;
      oring <= '0;
    end else begin
      ip    <= ip_next;
      op    <= op_next;
      irow  <= irow_next;
      icol  <= icol_next;
      iring <= iring_next;
      orow  <= orow_next;
      ocol  <= ocol_next;
      oring <= oring_next;
    end
  end

endmodule

@@ hw/rtl/bmw_lines.sv @@
`timescale 1ns / 1ps
module bmw_lines import bmw_pkg::*; #(
  parameter int M        = 7,
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  we,
  input  logic [$clog2(2*M)-1:0] w_ring,
  input  logic [$clog2(MAX_COLS+1)-1:0] w_col,
  input  logic                  w_pix,
  input  logic                  re,
  input  logic [$clog2(MAX_ROWS+1)-1:0] r_row,
  input  logic [$clog2(MAX_COLS+1)-1:0] r_col,
  input  logic [$clog2(2*M)-1:0] r_ring,
  input  logic                  r_last,
  output logic                  busy,
  output logic                  va,
  output logic [2*M-1:0][(1 << $clog2(2*M))-1:0] win,
  output logic [$clog2(MAX_ROWS+1)-1:0] q_row,
  output logic [$clog2(MAX_COLS+1)-1:0] q_col,
  output logic [$clog2(2*M)-1:0] q_ring,
  output logic                  q_last
);

  localparam int RING = 2 * M;
  localparam int B    = 1 << $clog2(2 * M);
  localparam int LB   = $clog2(B);
  localparam int D    = (MAX_COLS + B - 1) / B;
  localparam int AW   = (D > 1) ? $clog2(D) : 1;
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int GW   = $clog2(RING);
  localparam int XW   = CW + 2;

  logic [AW-1:0] clr_addr, w_addr, waddr;
  logic          wdat;
  logic [XW-1:0] base;
  logic [AW-1:0] ra   [B];
  logic [AW-1:0] ra_q [B];
  logic          rd   [RING][B];

  logic          byp_we, byp_pix;
  logic [GW-1:0] byp_ring;
  logic [LB-1:0] byp_bank;
  logic [AW-1:0] byp_addr;

  // clearing sweep after reset, all banks in parallel
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(D - 1)) busy <= 1'b0;
    end
  end

  assign w_addr = AW'(w_col >> LB);
  assign waddr  = busy ? clr_addr : w_addr;
  assign wdat   = busy ? 1'b0 : w_pix;

  // bank k supplies the window column with residue k, if the window has one
  always_comb begin
    logic [LB-1:0] off;
    logic [XW-1:0] colx;
    base = XW'(r_col) + XW'(B - (M - 1));
    for (int k = 0; k < B; k++) begin
      off   = LB'(k) - base[LB-1:0];
      colx  = base + XW'(off);
      ra[k] = AW'((colx - XW'(B)) >> LB);
    end
  end

  for (genvar g = 0; g < RING; g++) begin : g_ring
    for (genvar k = 0; k < B; k++) begin : g_bank
      logic mem [D];
      logic wsel;
      assign wsel = busy || (we && w_ring == GW'(g) && w_col[LB-1:0] == LB'(k));
      always_ff @(posedge clk) begin
        if (wsel) mem[waddr] <= wdat;
        if (re) rd[g][k] <= mem[ra[k]];
      end
      assign win[g][k] = (byp_we && byp_ring == GW'(g) && byp_bank == LB'(k) &&
                          byp_addr == ra_q[k]) ? byp_pix : rd[g][k];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      ra_q     <= ra;
      byp_we   <= we;
      byp_ring <= w_ring;
      byp_bank <= w_col[LB-1:0];
      byp_addr <= w_addr;
      byp_pix  <= w_pix;
      q_row    <= r_row;
      q_col    <= r_col;
      q_ring   <= r_ring;
      q_last   <= r_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else     va <= re;
  end

endmodule

@@ hw/rtl/bmw_eval.sv @@
`timescale 1ns / 1ps
module bmw_eval import bmw_pkg::*; #(
  parameter int M        = 7,
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  va,
  input  logic [2*M-1:0][(1 << $clog2(2*M))-1:0] win,
  input  logic [$clog2(MAX_ROWS+1)-1:0] q_row,
  input  logic [$clog2(MAX_COLS+1)-1:0] q_col,
  input  logic [$clog2(2*M)-1:0] q_ring,
  input  logic                  q_last,
  input  elem_cfg_t             ecfg,
  input  logic [$clog2(MAX_ROWS+1)-1:0] nrows,
  input  logic [$clog2(MAX_COLS+1)-1:0] ncols,
  output logic                  push,
  output logic                  push_pix,
  output logic                  push_last
);

  localparam int RING = 2 * M;
  localparam int B    = 1 << $clog2(2 * M);
  localparam int LB   = $clog2(B);
  localparam int GW   = $clog2(RING);
  localparam int N    = 2 * M - 1;
  localparam int IW   = (N > 1) ? $clog2(N) : 1;

  logic nb  [N][N];
  logic nbr [N][N];
  logic last_r;

  // neighbourhood around the result pixel, zero outside the image
  always_comb begin
    int rv, cv, rr;
    logic [GW-1:0] ri;
    logic [LB-1:0] bk;
    for (int i = 0; i < N; i++) begin
      rv = int'(q_row) + i - (M - 1);
      rr = int'(q_ring) + i + RING - (M - 1);
      if (rr >= RING) rr = rr - RING;
      if (rr >= RING) rr = rr - RING;
      ri = GW'(rr);
      for (int j = 0; j < N; j++) begin
        cv = int'(q_col) + j - (M - 1);
        bk = LB'((int'(q_col) + j + B - (M - 1)) % B);
        nb[i][j] = (rv >= 0) && (rv < int'(nrows)) && (cv >= 0) && (cv < int'(ncols)) &&
                   win[ri][bk];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (va) begin
      nbr    <= nb;
      last_r <= q_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else     push <= va;
  end

  always_comb begin
    logic acc;
    logic [IW-1:0] ii, jj;
    acc = ecfg.mode;
    for (int a = 0; a < M; a++) begin
      for (int b = 0; b < M; b++) begin
        if (ecfg.mode) begin
          ii = IW'(a - int'(ecfg.orow) + M - 1);
          jj = IW'(b - int'(ecfg.ocol) + M - 1);
        end else begin
          ii = IW'(int'(ecfg.orow) - a + M - 1);
          jj = IW'(int'(ecfg.ocol) - b + M - 1);
        end
        if (a < int'(ecfg.rows) && b < int'(ecfg.cols) && ecfg.mask[a*MASK_STRIDE+b]) begin
          if (ecfg.mode) begin
            if (!nbr[ii][jj]) acc = 1'b0;
          end else begin
            if (nbr[ii][jj]) acc = 1'b1;
          end
        end
      end
    end
    push_pix = acc;
  end

  assign push_last = last_r;

endmodule

@@ hw/rtl/bmw_queue.sv @@
`timescale 1ns / 1ps
module bmw_queue import bmw_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  logic           push_pix,
  input  logic           push_last,
  output logic [QLW-1:0] level,
  bmw_out_if.source      out_ch
);

  logic           pix_q  [QDEPTH];
  logic           last_q [QDEPTH];
  logic [QAW-1:0] wp, rp;
  logic           pop;

  assign pop               = out_ch.valid && out_ch.ready;
  assign out_ch.valid      = (level != '0);
  assign out_ch.pixel_out  = pix_q[rp];
  assign out_ch.frame_last = last_q[rp];

  always_ff @(posedge clk) begin
    if (push) begin
      pix_q[wp]  <= push_pix;
      last_q[wp] <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop)  rp <= rp + 1'b1;
      if (push && !pop)      level <= level + 1'b1;
      else if (pop && !push) level <= level - 1'b1;
    end
  end

endmodule

@@ hw/rtl/binary_morphology_window.sv @@
// Binary dilation / erosion over a raster stream, one item per cycle while output is taken.
// A result leaves through the line store read register, the neighbourhood register and
// the output queue after the item that completes its window.
// A configuration write recomputes row and column positions by a serial division; no items taken.
// Synchronous reset; the line store is then cleared, all banks in parallel,
// before the first item is taken. Registers reset to dilation, empty 3x3 element, 1024x1024.
`timescale 1ns / 1ps
module binary_morphology_window import bmw_pkg::*; #(
  parameter int MAX_ELEMENT = 7,
  parameter int MAX_COLS    = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic             clk,
  input  logic             rst,
  bmw_in_if.sink           in_ch,
  bmw_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [REG_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int M    = MAX_ELEMENT;
  localparam int RW   = $clog2(MAX_ROWS + 1);
  localparam int CW   = $clog2(MAX_COLS + 1);
  localparam int GW   = $clog2(2 * M);
  localparam int B    = 1 << $clog2(2 * M);

  elem_cfg_t       ecfg;
  logic [RW-1:0]   nrows, j_row, q_row;
  logic [CW-1:0]   ncols, w_col, j_col, q_col;
  logic [GW-1:0]   w_ring, j_ring, q_ring;
  logic            we, w_pix, re, j_last, q_last;
  logic            clr_busy, va, push, push_pix, push_last, room;
  logic [QLW-1:0]  level;
  logic [QLW:0]    inflight;
  logic [2*M-1:0][B-1:0] win;

  // every read in flight has a queue slot waiting for it
  assign inflight = {1'b0, level} + {{QLW{1'b0}}, va} + {{QLW{1'b0}}, push};
  assign room     = inflight < (QLW + 1)'(QDEPTH);

  bmw_front #(.M(M), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .in_ch, .room, .clr_busy,
    .ecfg, .nrows, .ncols, .we, .w_ring, .w_col, .w_pix,
    .re, .j_row, .j_col, .j_ring, .j_last
  );

  bmw_lines #(.M(M), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_lines (
    .clk, .rst, .we, .w_ring, .w_col, .w_pix,
    .re, .r_row(j_row), .r_col(j_col), .r_ring(j_ring), .r_last(j_last),
    .busy(clr_busy), .va, .win, .q_row, .q_col, .q_ring, .q_last
  );

  bmw_eval #(.M(M), .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_eval (
    .clk, .rst, .va, .win, .q_row, .q_col, .q_ring, .q_last,
    .ecfg, .nrows, .ncols, .push, .push_pix, .push_last
  );

  bmw_queue u_queue (
    .clk, .rst, .push, .push_pix, .push_last, .level, .out_ch
  );

endmodule
